FILE: src/nbc_pkg.sv
package nbc_pkg;

    // Request codes
    localparam logic REQ_TRAIN    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_BITS = 2;
    localparam int          CFG_DATA_BITS = 4;
    localparam logic [1:0]  CFG_LABELS   = 2'd0;
    localparam logic [1:0]  CFG_ATTRS    = 2'd1;
    localparam logic [3:0]  LABELS_RESET = 4'd4;
    localparam logic [3:0]  ATTRS_RESET  = 4'd6;

    // Field widths fixed by the interface
    localparam int VALUE_BITS = 4;
    localparam int LABEL_BITS = 3;
    localparam int NUM_VALUE_PORTS = 8;

    // Limb width of the serial wide multiplier
    localparam int LIMB_BITS = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TR_RD,
        ST_TR_WR,
        ST_CX_RD,
        ST_CX_MUL,
        ST_CMP,
        ST_DONE
    } t_state;

    // Per-lane count memory control
    typedef struct packed {
        logic clr;
        logic rd;
        logic inc;
    } t_lane_ctl;

endpackage

FILE: src/nbc_lane.sv
module nbc_lane
    import nbc_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int COUNT_BITS = 16,
    parameter int ADDR_BITS  = 7
) (
    input  logic                  i_clk,
    input  t_lane_ctl             i_ctl,
    input  logic [ADDR_BITS-1:0]  i_addr,
    output logic [COUNT_BITS-1:0] o_q
);

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_q;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [COUNT_BITS-1:0] n_sat;

    // saturating increment of the last word read
    always_comb begin
        n_sat = (r_q == {COUNT_BITS{1'b1}}) ? r_q : r_q + 1'b1;
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_mem[i_addr] <= '0;
        end else if (i_ctl.inc) begin
            r_mem[r_addr] <= n_sat;
        end
        if (i_ctl.rd) begin
            r_q    <= r_mem[i_addr];
            r_addr <= i_addr;
        end
    end

    assign o_q = r_q;

endmodule

FILE: src/nbc_wide_mul.sv
module nbc_wide_mul
    import nbc_pkg::*;
#(
    parameter int FACTOR_BITS = 17,
    parameter int NUM_LIMBS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_init,
    input  logic                           i_en,
    input  logic [FACTOR_BITS-1:0]         i_factor,
    output logic [NUM_LIMBS*LIMB_BITS-1:0] o_acc,
    output logic                           o_last
);

    localparam int ACC_BITS  = NUM_LIMBS * LIMB_BITS;
    localparam int PROD_BITS = LIMB_BITS + FACTOR_BITS;
    localparam int CNT_BITS  = $clog2(NUM_LIMBS + 1);

    logic [ACC_BITS-1:0]    r_acc;
    logic [FACTOR_BITS-1:0] r_carry;
    logic [CNT_BITS-1:0]    r_limb;
    logic [PROD_BITS-1:0]   n_prod;

    // one limb times the factor plus the running carry
    always_comb begin
        n_prod = PROD_BITS'(r_acc[LIMB_BITS-1:0]) * PROD_BITS'(i_factor)
               + PROD_BITS'(r_carry);
    end

    assign o_last = (r_limb == CNT_BITS'(NUM_LIMBS - 1));

    // limb counter and carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_limb  <= '0;
            r_carry <= '0;
        end else if (i_en) begin
            if (o_last) begin
                r_limb  <= '0;
                r_carry <= '0;
            end else begin
                r_limb  <= r_limb + 1'b1;
                r_carry <= n_prod[PROD_BITS-1:LIMB_BITS];
            end
        end
    end

    // accumulator rotates one limb per cycle while enabled
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_acc <= ACC_BITS'(1);
        end else if (i_en) begin
            r_acc <= {n_prod[LIMB_BITS-1:0], r_acc[ACC_BITS-1:LIMB_BITS]};
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: src/naive_bayes_categorical_classifier.sv
// Train transaction: counts read in ST_TR_RD, incremented in ST_TR_WR, then back in idle.
// Classify transaction: cross products of the scores of the L labels over the A attributes in use,
// NL = 16 limbs by default, computed by the serial 16-bit limb multiplier.
// One transaction in flight; a result register lets the next one start while it waits.
// Synchronous active-low reset; afterwards the count memories are swept to zero over all
// MAX_CLASSES * MAX_VALUES addresses (128 by default) with the input stalled.
module naive_bayes_categorical_classifier
    import nbc_pkg::*;
#(
    parameter int MAX_CLASSES    = 8,
    parameter int MAX_ATTRIBUTES = 8,
    parameter int MAX_VALUES     = 16,
    parameter int COUNT_BITS     = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_req_type,
    input  logic [2:0]               i_class_label,
    input  logic [3:0]               i_value_a0,
    input  logic [3:0]               i_value_a1,
    input  logic [3:0]               i_value_a2,
    input  logic [3:0]               i_value_a3,
    input  logic [3:0]               i_value_a4,
    input  logic [3:0]               i_value_a5,
    input  logic [3:0]               i_value_a6,
    input  logic [3:0]               i_value_a7,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_predicted_class
);

    localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int VW    = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int DEPTH = MAX_CLASSES * MAX_VALUES;
    localparam int DW    = $clog2(DEPTH);
    localparam int FW    = COUNT_BITS + 1;
    localparam int NL    = ((2 * MAX_ATTRIBUTES - 1) * FW + LIMB_BITS - 1) / LIMB_BITS;
    localparam int ACCW  = NL * LIMB_BITS;
    localparam int FIW   = $clog2(2 * MAX_ATTRIBUTES);

    t_state r_state, n_state;

    logic [CFG_DATA_BITS-1:0] r_cfg_l, r_cfg_a;
    logic [CFG_DATA_BITS-1:0] eff_l, eff_a;

    logic [VALUE_BITS-1:0] in_vals [NUM_VALUE_PORTS];
    logic [VW-1:0]         r_vals  [MAX_ATTRIBUTES];
    logic [LABEL_BITS-1:0] r_lab;
    logic [COUNT_BITS-1:0] r_cc [MAX_CLASSES];
    logic [CW-1:0]         r_best, r_k;
    logic                  r_phase;
    logic [FIW-1:0]        r_fidx;
    logic [ACCW-1:0]       r_lhs;
    logic [DW-1:0]         r_clr_addr;
    logic                  r_ov;
    logic [2:0]            r_out;

    logic [CW-1:0]         kn, kd, cc_idx;
    logic [COUNT_BITS-1:0] cc_q;
    logic [COUNT_BITS-1:0] lane_q [MAX_ATTRIBUTES];
    t_lane_ctl             lane_ctl [MAX_ATTRIBUTES];
    logic [DW-1:0]         lane_addr [MAX_ATTRIBUTES];
    logic [FW-1:0]         factor;
    logic [COUNT_BITS-1:0] sel_q;
    logic                  mul_init, mul_en, mul_last;
    logic [ACCW-1:0]       mul_acc;
    logic                  in_acc, out_acc, fac_last, k_last, lab_ok;

    // clamp of a value index to the table
    function automatic logic [VW-1:0] clamp_val(input logic [VALUE_BITS-1:0] v);
        logic [VW+VALUE_BITS-1:0] ext;
        ext = (VW + VALUE_BITS)'(v);
        clamp_val = (ext >= (VW + VALUE_BITS)'(MAX_VALUES - 1))
                  ? VW'(MAX_VALUES - 1) : ext[VW-1:0];
    endfunction

    assign in_vals[0] = i_value_a0;
    assign in_vals[1] = i_value_a1;
    assign in_vals[2] = i_value_a2;
    assign in_vals[3] = i_value_a3;
    assign in_vals[4] = i_value_a4;
    assign in_vals[5] = i_value_a5;
    assign in_vals[6] = i_value_a6;
    assign in_vals[7] = i_value_a7;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ov && !i_stall;

    // configuration registers and their effective values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_l <= LABELS_RESET;
            r_cfg_a <= ATTRS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LABELS: r_cfg_l <= i_cfg_data;
                CFG_ATTRS:  r_cfg_a <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_l = r_cfg_l;
        if (eff_l < CFG_DATA_BITS'(2))           eff_l = CFG_DATA_BITS'(2);
        if (32'(eff_l) > MAX_CLASSES)            eff_l = CFG_DATA_BITS'(MAX_CLASSES);
        eff_a = r_cfg_a;
        if (eff_a < CFG_DATA_BITS'(1))           eff_a = CFG_DATA_BITS'(1);
        if (32'(eff_a) > MAX_ATTRIBUTES)         eff_a = CFG_DATA_BITS'(MAX_ATTRIBUTES);
    end

    // class roles in the current cross product
    assign kn     = r_phase ? r_best : r_k;
    assign kd     = r_phase ? r_k : r_best;
    assign cc_idx = (r_state == ST_TR_WR) ? CW'(r_lab) : kd;
    assign cc_q   = r_cc[cc_idx];
    assign lab_ok = (32'(r_lab) < 32'(eff_l));

    // factor selection: attribute counts first, then class denominators
    always_comb begin
        sel_q = '0;
        for (int a = 0; a < MAX_ATTRIBUTES; a++) begin
            if (32'(r_fidx) == a) sel_q = lane_q[a];
        end
        if (32'(r_fidx) < 32'(eff_a)) factor = FW'(sel_q) + FW'(1);
        else                          factor = FW'(cc_q) + FW'(eff_l);
    end

    assign fac_last = (32'(r_fidx) == 2 * 32'(eff_a) - 2);
    assign k_last   = (32'(r_k) + 1 == 32'(eff_l));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (32'(r_clr_addr) == DEPTH - 1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) n_state = (i_req_type == REQ_TRAIN) ? ST_TR_RD : ST_CX_RD;
            end
            ST_TR_RD:  n_state = lab_ok ? ST_TR_WR : ST_IDLE;
            ST_TR_WR:  n_state = ST_IDLE;
            ST_CX_RD:  n_state = ST_CX_MUL;
            ST_CX_MUL: begin
                if (mul_last && fac_last) n_state = r_phase ? ST_CMP : ST_CX_RD;
            end
            ST_CMP:    n_state = k_last ? ST_DONE : ST_CX_RD;
            ST_DONE:   if (!r_ov || out_acc) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall  = (r_state != ST_IDLE);
        mul_init = (r_state == ST_CX_RD);
        mul_en   = (r_state == ST_CX_MUL);
        for (int a = 0; a < MAX_ATTRIBUTES; a++) begin
            lane_ctl[a].clr = (r_state == ST_CLEAR);
            lane_ctl[a].rd  = (r_state == ST_TR_RD) || (r_state == ST_CX_RD);
            lane_ctl[a].inc = (r_state == ST_TR_WR) && (a < 32'(eff_a));
            if (r_state == ST_CLEAR) begin
                lane_addr[a] = r_clr_addr;
            end else if (r_state == ST_TR_RD) begin
                lane_addr[a] = DW'(32'(r_lab) * MAX_VALUES + 32'(r_vals[a]));
            end else begin
                lane_addr[a] = DW'(32'(kn) * MAX_VALUES + 32'(r_vals[a]));
            end
        end
    end

    // state and sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ov       <= 1'b0;
            r_phase    <= 1'b0;
            r_fidx     <= '0;
            r_best     <= '0;
            r_k        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (r_state == ST_IDLE && in_acc) begin
                r_best  <= '0;
                r_k     <= CW'(1);
                r_phase <= 1'b0;
            end
            if (r_state == ST_CX_RD) r_fidx <= '0;
            if (r_state == ST_CX_MUL && mul_last) begin
                if (fac_last) r_phase <= ~r_phase;
                else          r_fidx  <= r_fidx + 1'b1;
            end
            if (r_state == ST_CMP) begin
                if (r_lhs > mul_acc) r_best <= r_k;
                r_k <= r_k + 1'b1;
            end
            if (r_state == ST_DONE && (!r_ov || out_acc)) r_ov <= 1'b1;
            else if (out_acc)                             r_ov <= 1'b0;
        end
    end

    // class counts, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CLASSES; k++) r_cc[k] <= '0;
        end else if (r_state == ST_TR_WR && cc_q != {COUNT_BITS{1'b1}}) begin
            r_cc[cc_idx] <= cc_q + 1'b1;
        end
    end

    // transaction payload and result; first product taken once fully rotated
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_lab <= i_class_label;
            for (int a = 0; a < MAX_ATTRIBUTES; a++) r_vals[a] <= clamp_val(in_vals[a]);
        end
        if (r_state == ST_CX_RD && r_phase) r_lhs <= mul_acc;
        if (r_state == ST_DONE && (!r_ov || out_acc)) r_out <= 3'(r_best);
    end

    // one count lane per attribute
    for (genvar g = 0; g < MAX_ATTRIBUTES; g++) begin : g_lane
        nbc_lane #(
            .DEPTH      (DEPTH),
            .COUNT_BITS (COUNT_BITS),
            .ADDR_BITS  (DW)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl[g]),
            .i_addr (lane_addr[g]),
            .o_q    (lane_q[g])
        );
    end

    nbc_wide_mul #(
        .FACTOR_BITS (FW),
        .NUM_LIMBS   (NL)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_init   (mul_init),
        .i_en     (mul_en),
        .i_factor (factor),
        .o_acc    (mul_acc),
        .o_last   (mul_last)
    );

    assign o_valid           = r_ov;
    assign o_predicted_class = r_out;

endmodule

FILE: src/nbc_checker.sv
module nbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_req_type,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_predicted_class
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_predicted_class))
        else $error("result changed while stalled");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while busy");

    // training gives no result
    a_train_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_req_type && !o_valid |=> !o_valid)
        else $error("result after train transaction");

    // clearing sweep after reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("not busy after reset");

endmodule

bind naive_bayes_categorical_classifier nbc_checker u_nbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_req_type        (i_req_type),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_predicted_class (o_predicted_class)
);

FILE: sim/naive_bayes_categorical_classifier_tb.sv
`timescale 1ns / 1ps

module naive_bayes_categorical_classifier_tb;
    import nbc_pkg::*;

    localparam int  N_CLASS   = 8;
    localparam int  N_ATTR    = 8;
    localparam int  N_VAL     = 16;
    localparam int  CNT_BITS  = 16;
    localparam int  LIMIT     = 6000000;
    localparam int  HOLD_LEN  = 5000;
    localparam int  IDLE_PCT  = 38;

    typedef logic [3:0] t_vals [N_ATTR];
    typedef logic [319:0] t_wide;

    typedef struct {
        logic       req;
        logic [2:0] label;
        t_vals      vals;
        bit         typed;
        logic [2:0] want;
    } t_row;

    typedef struct {
        logic [3:0] labels;
        logic [3:0] attrs;
        int         items;
    } t_phase;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_req_type = REQ_TRAIN;
    logic [2:0]               i_class_label = '0;
    logic [3:0]               i_value_a0 = '0, i_value_a1 = '0, i_value_a2 = '0;
    logic [3:0]               i_value_a3 = '0, i_value_a4 = '0, i_value_a5 = '0;
    logic [3:0]               i_value_a6 = '0, i_value_a7 = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [2:0]               o_predicted_class;

    naive_bayes_categorical_classifier uut (.*);

    // Mirror of the classifier state
    logic [3:0]          mir_labels;
    logic [3:0]          mir_attrs;
    logic [CNT_BITS-1:0] class_tally [N_CLASS];
    logic [CNT_BITS-1:0] cell_tally [N_CLASS][N_ATTR][N_VAL];

    logic [2:0] class_q [$];
    int         n_bad = 0;
    int         n_accepted = 0;
    int         cyc = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_labels();
        int l;
        l = mir_labels;
        if (l < 2) l = 2;
        if (l > N_CLASS) l = N_CLASS;
        return l;
    endfunction

    function automatic int eff_attrs();
        int a;
        a = mir_attrs;
        if (a < 1) a = 1;
        if (a > N_ATTR) a = N_ATTR;
        return a;
    endfunction

    // Count update for a labelled sample, saturating
    function automatic void learn(logic [2:0] lab, t_vals v);
        if (lab >= eff_labels()) return;
        if (class_tally[lab] != '1) class_tally[lab]++;
        for (int a = 0; a < eff_attrs(); a++)
            if (cell_tally[lab][a][v[a]] != '1) cell_tally[lab][a][v[a]]++;
    endfunction

    // Exact arg-max of the smoothed score by cross-multiplication
    function automatic logic [2:0] best_class(t_vals v);
        t_wide num [N_CLASS];
        t_wide den [N_CLASS];
        int    nl, na, best;
        nl = eff_labels();
        na = eff_attrs();
        for (int k = 0; k < nl; k++) begin
            num[k] = t_wide'(1);
            den[k] = t_wide'(1);
            for (int a = 0; a < na; a++) num[k] = num[k] * (cell_tally[k][a][v[a]] + 1);
            for (int a = 1; a < na; a++) den[k] = den[k] * (class_tally[k] + nl);
        end
        best = 0;
        for (int k = 1; k < nl; k++)
            if (num[k] * den[best] > num[best] * den[k]) best = k;
        return best[2:0];
    endfunction

    // Configuration write; the mirror follows only the listed registers
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_LABELS) mir_labels = data;
        else if (idx == CFG_ATTRS) mir_attrs = data;
        @(posedge i_clk);
    endtask

    function automatic bit quiet();
        return n_accepted >= 300 && n_accepted < 420;
    endfunction

    // One input transaction, optional idle first, predicted on acceptance
    task automatic send(t_row r);
        while (!quiet() && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= r.req;
        i_class_label <= r.label;
        i_value_a0 <= r.vals[0]; i_value_a1 <= r.vals[1];
        i_value_a2 <= r.vals[2]; i_value_a3 <= r.vals[3];
        i_value_a4 <= r.vals[4]; i_value_a5 <= r.vals[5];
        i_value_a6 <= r.vals[6]; i_value_a7 <= r.vals[7];
        do @(posedge i_clk); while (o_stall);
        n_accepted++;
        if (r.req == REQ_CLASSIFY) class_q.push_back(r.typed ? r.want : best_class(r.vals));
        else learn(r.label, r.vals);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (class_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_vals fill(logic [3:0] x);
        t_vals v;
        foreach (v[a]) v[a] = x;
        return v;
    endfunction

    // Result side: stall, long hold-off, timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (n_accepted >= 480 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (quiet()) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (class_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result: class %0d", o_predicted_class);
            end else begin
                if (o_predicted_class !== class_q[0]) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("class mismatch: expected %0d actual %0d",
                                 class_q[0], o_predicted_class);
                end
                void'(class_q.pop_front());
            end
        end
    end

    initial begin
        t_row   dir [$];
        t_row   r;
        t_phase plan [7];
        t_vals  v;

        mir_labels = LABELS_RESET;
        mir_attrs  = ATTRS_RESET;
        foreach (class_tally[k]) class_tally[k] = '0;
        foreach (cell_tally[k, a, x]) cell_tally[k][a][x] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty counts give class 0, then unused label, extremes
        dir.push_back('{REQ_CLASSIFY, 3'd5, fill(4'd0),  1'b1, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd0, fill(4'd15), 1'b1, 3'd0});
        dir.push_back('{REQ_TRAIN,    3'd7, fill(4'd15), 1'b0, 3'd0});
        dir.push_back('{REQ_TRAIN,    3'd4, fill(4'd15), 1'b0, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd7, fill(4'd15), 1'b1, 3'd0});
        dir.push_back('{REQ_TRAIN,    3'd3, fill(4'd15), 1'b0, 3'd0});
        dir.push_back('{REQ_TRAIN,    3'd3, fill(4'd15), 1'b0, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd0, fill(4'd15), 1'b1, 3'd3});
        dir.push_back('{REQ_TRAIN,    3'd1, fill(4'd0),  1'b0, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd0, fill(4'd0),  1'b1, 3'd1});
        dir.push_back('{REQ_TRAIN,    3'd2, fill(4'd10), 1'b0, 3'd0});
        dir.push_back('{REQ_TRAIN,    3'd0, fill(4'd5),  1'b0, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd0, fill(4'd10), 1'b0, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd0, fill(4'd5),  1'b0, 3'd0});
        dir.push_back('{REQ_CLASSIFY, 3'd0, fill(4'd7),  1'b0, 3'd0});
        foreach (dir[i]) send(dir[i]);
        drain();

        // Indexes beyond the register list are ignored
        write_reg(2'd2, 4'hF);
        write_reg(2'd3, 4'h0);

        plan = '{'{4'd2, 4'd1, 150}, '{4'd8, 4'd8, 110}, '{4'd0, 4'd0, 160},
                 '{4'd15, 4'd15, 70}, '{4'd3, 4'd4, 250}, '{4'd5, 4'd2, 250},
                 '{4'd4, 4'd6, 150}};
        foreach (plan[p]) begin
            write_reg(CFG_LABELS, plan[p].labels);
            write_reg(CFG_ATTRS, plan[p].attrs);
            for (int i = 0; i < plan[p].items; i++) begin
                foreach (v[a])
                    v[a] = 4'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 15));
                r.req   = ($urandom_range(0, 99) < 70) ? REQ_TRAIN : REQ_CLASSIFY;
                r.label = 3'($urandom_range(0, 7));
                r.vals  = v;
                r.typed = 1'b0;
                r.want  = '0;
                send(r);
            end
            drain();
        end

        if (n_bad == 0 && class_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
